// ----- hw/rtl/slhm_pkg.sv -----
// ----------------------------------------------------------------------------
// slhm_pkg
// Shared widths, status codes, register indexes and reset values of the
// supply level hysteresis monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package slhm_pkg;

   // converter default and scaling
   localparam int ADC_BITS_DEF = 12;
   localparam int LEVEL_W      = 12;
   localparam int FULL_SCALE   = 3300;

   // signed compare width: covers threshold +/- band (-255 .. 4350)
   localparam int CMP_W        = 14;

   // status codes
   localparam int STATUS_W = 3;
   localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_WARNING  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CRITICAL = 3'd4;

   // register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int BAND_W     = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_FULL_LEVEL     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARNING_LEVEL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_LEVEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST_BAND      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENCE_LEVEL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MARGIN    = 3'd5;

   localparam logic [LEVEL_W-1:0] RST_FULL_LEVEL     = 12'd424;
   localparam logic [LEVEL_W-1:0] RST_WARNING_LEVEL  = 12'd350;
   localparam logic [LEVEL_W-1:0] RST_CRITICAL_LEVEL = 12'd330;
   localparam logic [BAND_W-1:0]  RST_HYST_BAND      = 8'd10;
   localparam logic [LEVEL_W-1:0] RST_PRESENCE_LEVEL = 12'd100;
   localparam logic [BAND_W-1:0]  RST_FULL_MARGIN    = 8'd14;

endpackage

`default_nettype wire

// ----- hw/rtl/supply_level_hysteresis_monitor.sv -----
// ----------------------------------------------------------------------------
// supply_level_hysteresis_monitor
// Throughput: one sample per cycle while results are taken. The input
// register refills in the cycle its item moves to the result register.
// While a result waits, one more sample is taken if the input register
// is empty, then the input holds.
// Reset (synchronous, active high) empties both registers, sets the status to
// absent, clears the plug-in flag and loads the default thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

// Scales each converter sample to a 0..3300 level and tracks a five-state
// supply status (absent, full, ok, warning, critical) with hysteresis.
//
// Datapath:
//   input    sample register
//   output   product sample * 3300, level = floor(product / (2^ADC_BITS - 1)),
//            status update against the thresholds; level, status and the
//            plug-in flag are the result registers
//
// The division by 2^n-1 uses the series 1/(2^n-1) = 2^-n + 2^-2n + ...,
// which lands at most one below the true quotient; a single remainder check
// corrects it.
module supply_level_hysteresis_monitor #(
   parameter int ADC_BITS = slhm_pkg::ADC_BITS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   // sample channel
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [ADC_BITS-1:0]             req_adc_sample,
   // result channel
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [slhm_pkg::LEVEL_W-1:0]    rsp_level,
   output logic [slhm_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_full_at_plug_in,
   // register write port
   input  wire                             csr_write_en,
   input  wire  [slhm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [slhm_pkg::CSR_DATA_W-1:0] csr_data
);
   import slhm_pkg::*;

   localparam int PROD_W = ADC_BITS + LEVEL_W;          // sample * 3300 fits
   localparam logic [ADC_BITS-1:0] MAX_CODE = {ADC_BITS{1'b1}};

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [LEVEL_W-1:0] full_level_ff,     full_level_in;
   logic [LEVEL_W-1:0] warning_level_ff,  warning_level_in;
   logic [LEVEL_W-1:0] critical_level_ff, critical_level_in;
   logic [BAND_W-1:0]  hyst_band_ff,      hyst_band_in;
   logic [LEVEL_W-1:0] presence_level_ff, presence_level_in;
   logic [BAND_W-1:0]  full_margin_ff,    full_margin_in;

   always_comb begin
      full_level_in     = full_level_ff;
      warning_level_in  = warning_level_ff;
      critical_level_in = critical_level_ff;
      hyst_band_in      = hyst_band_ff;
      presence_level_in = presence_level_ff;
      full_margin_in    = full_margin_ff;
      if (csr_write_en) begin
         // drop data bits above a register's width; ignore unknown indexes
         unique case (csr_index)
            CSR_FULL_LEVEL:     full_level_in     = csr_data[LEVEL_W-1:0];
            CSR_WARNING_LEVEL:  warning_level_in  = csr_data[LEVEL_W-1:0];
            CSR_CRITICAL_LEVEL: critical_level_in = csr_data[LEVEL_W-1:0];
            CSR_HYST_BAND:      hyst_band_in      = csr_data[BAND_W-1:0];
            CSR_PRESENCE_LEVEL: presence_level_in = csr_data[LEVEL_W-1:0];
            CSR_FULL_MARGIN:    full_margin_in    = csr_data[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_level_ff     <= RST_FULL_LEVEL;
         warning_level_ff  <= RST_WARNING_LEVEL;
         critical_level_ff <= RST_CRITICAL_LEVEL;
         hyst_band_ff      <= RST_HYST_BAND;
         presence_level_ff <= RST_PRESENCE_LEVEL;
         full_margin_ff    <= RST_FULL_MARGIN;
      end else begin
         full_level_ff     <= full_level_in;
         warning_level_ff  <= warning_level_in;
         critical_level_ff <= critical_level_in;
         hyst_band_ff      <= hyst_band_in;
         presence_level_ff <= presence_level_in;
         full_margin_ff    <= full_margin_in;
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: the input register loads when it is empty or when its
   // item moves to the result register in the same cycle.
   // ---------------------------------------------------------------------
   logic v0_ff, v0_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic free0, free1;

   assign free1 = !rsp_valid_ff || rsp_ready;
   assign free0 = !v0_ff || free1;

   assign req_ready = free0;

   assign v0_in        = free0 ? req_valid : v0_ff;
   assign rsp_valid_in = free1 ? v0_ff     : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v0_ff        <= v0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input register: capture the sample
   // ---------------------------------------------------------------------
   logic [ADC_BITS-1:0] sample_ff;

   always_ff @(posedge clock) begin
      if (free0 && req_valid) begin
         sample_ff <= req_adc_sample;
      end
   end

   // ---------------------------------------------------------------------
   // Scale: multiply by full scale, then divide the product by 2^n-1
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0]    prod;
   logic [PROD_W:0]      quo_sum;      // p + p>>n + p>>2n
   logic [LEVEL_W-1:0]   quo_est;      // at most one below the quotient
   logic [PROD_W:0]      quo_back;     // quo_est * (2^n-1)
   logic [PROD_W:0]      quo_rem;
   logic                 quo_fix;
   logic [LEVEL_W-1:0]   level;

   always_comb begin
      prod     = PROD_W'(sample_ff) * PROD_W'(FULL_SCALE);
      quo_sum  = (PROD_W+1)'(prod) + (PROD_W+1)'(prod >> ADC_BITS)
               + (PROD_W+1)'(prod >> (2 * ADC_BITS));
      quo_est  = quo_sum[ADC_BITS +: LEVEL_W];
      quo_back = ((PROD_W+1)'(quo_est) << ADC_BITS) - (PROD_W+1)'(quo_est);
      quo_rem  = (PROD_W+1)'(prod) - quo_back;
      quo_fix  = (quo_rem >= (PROD_W+1)'(MAX_CODE));
      level    = quo_est + LEVEL_W'(quo_fix);
   end

   // ---------------------------------------------------------------------
   // Status update. All compares are signed and wide enough that
   // threshold +/- band never wraps; a negative lower threshold simply
   // never trips.
   // ---------------------------------------------------------------------
   logic [STATUS_W-1:0] status_ff, status_in, status_mid;
   logic                flag_ff, flag_in;
   logic [LEVEL_W-1:0]  rsp_level_ff;

   logic signed [CMP_W-1:0] lvl_s;
   logic signed [CMP_W-1:0] full_up, full_dn, warn_up, warn_dn;
   logic signed [CMP_W-1:0] crit_up, crit_dn, pres_s, plug_full_s;

   always_comb begin
      lvl_s       = signed'(CMP_W'(level));
      full_up     = signed'(CMP_W'(full_level_ff) + CMP_W'(hyst_band_ff));
      full_dn     = signed'(CMP_W'(full_level_ff) - CMP_W'(hyst_band_ff));
      warn_up     = signed'(CMP_W'(warning_level_ff) + CMP_W'(hyst_band_ff));
      warn_dn     = signed'(CMP_W'(warning_level_ff) - CMP_W'(hyst_band_ff));
      crit_up     = signed'(CMP_W'(critical_level_ff) + CMP_W'(hyst_band_ff));
      crit_dn     = signed'(CMP_W'(critical_level_ff) - CMP_W'(hyst_band_ff));
      pres_s      = signed'(CMP_W'(presence_level_ff));
      plug_full_s = signed'(CMP_W'(full_level_ff) - CMP_W'(full_margin_ff));
   end

   always_comb begin
      status_mid = status_ff;
      flag_in    = flag_ff;
      // plug-in: enter ok and latch whether the level was near full;
      // unplug: drop to absent
      if (status_ff == ST_ABSENT && lvl_s > pres_s) begin
         status_mid = ST_OK;
         flag_in    = (lvl_s >= plug_full_s);
      end else if (status_ff != ST_ABSENT && lvl_s <= pres_s) begin
         status_mid = ST_ABSENT;
      end

      status_in = status_mid;
      unique case (status_mid)
         ST_FULL: begin
            if (lvl_s <= full_dn) status_in = ST_OK;
         end
         ST_OK: begin
            if (lvl_s <= warn_dn)      status_in = ST_WARNING;
            else if (lvl_s > full_up)  status_in = ST_FULL;
         end
         ST_WARNING: begin
            if (lvl_s <= crit_dn)      status_in = ST_CRITICAL;
            else if (lvl_s > warn_up)  status_in = ST_OK;
         end
         ST_CRITICAL: begin
            if (lvl_s > crit_up) status_in = ST_WARNING;
         end
         default: ;
      endcase
   end

   // the status register doubles as the result field: it only advances
   // when a new result enters the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_ABSENT;
         flag_ff   <= 1'b0;
      end else if (free1 && v0_ff) begin
         status_ff <= status_in;
         flag_ff   <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free1 && v0_ff) begin
         rsp_level_ff <= level;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_level           = rsp_level_ff;
   assign rsp_status          = status_ff;
   assign rsp_full_at_plug_in = flag_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/slhm_checker.sv -----
// ----------------------------------------------------------------------------
// slhm_checker
// Port-level assertions for the supply level hysteresis monitor, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slhm_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             rsp_valid,
   input wire                             rsp_ready,
   input wire [slhm_pkg::LEVEL_W-1:0]     rsp_level,
   input wire [slhm_pkg::STATUS_W-1:0]    rsp_status,
   input wire                             rsp_full_at_plug_in
);
   import slhm_pkg::*;

   // no result may survive a reset
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds its payload
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level)
         && $stable(rsp_status) && $stable(rsp_full_at_plug_in))
      else $error("stalled result changed");

   // scaled level never exceeds full scale
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level <= LEVEL_W'(FULL_SCALE))
      else $error("level above full scale");

   // only the five defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_CRITICAL)
      else $error("undefined status code");

   // plug-in flag only changes on a result that leaves the absent state
   a_flag_on_plug: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && $past(rsp_status) != ST_ABSENT
         && rsp_status != ST_OK |=> 1'b1 ##0 (!rsp_valid
         || rsp_full_at_plug_in == $past(rsp_full_at_plug_in)
         || rsp_status == ST_OK || rsp_status == ST_FULL
         || rsp_status == ST_WARNING))
      else $error("plug-in flag changed without a plug-in");

endmodule

bind supply_level_hysteresis_monitor slhm_checker u_slhm_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_level           (rsp_level),
   .rsp_status          (rsp_status),
   .rsp_full_at_plug_in (rsp_full_at_plug_in)
);

`default_nettype wire

// ----- sim/supply_level_hysteresis_monitor_tb.sv -----
// ----------------------------------------------------------------------------
// supply_level_hysteresis_monitor_tb
// Streams converter samples through the monitor under random idling on both
// channels and compares every result (level, status, plug-in flag) against an
// in-bench prediction of the status machine, across several threshold sets.
// ----------------------------------------------------------------------------
module supply_level_hysteresis_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import slhm_pkg::*;

   localparam int MAX_CODE = (1 << ADC_BITS_DEF) - 1;

   // register indexes past the end of the register file; writes must vanish
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic [STATUS_W-1:0] status;
      logic                plug;
   } level_result_type;

   // -------------------------------------------------------------------------
   // Status tracker: mirrors the thresholds and the status machine, holds the
   // results still owed by the block, and checks each one that arrives.
   // -------------------------------------------------------------------------
   class level_scoreboard_type;
      logic [LEVEL_W-1:0]  full_lvl, warn_lvl, crit_lvl, pres_lvl;
      logic [BAND_W-1:0]   band_w, margin_w;
      logic [STATUS_W-1:0] status_q;
      logic                plug_flag;
      level_result_type    owed_q[$];
      int                  errors;

      function new();
         full_lvl  = RST_FULL_LEVEL;
         warn_lvl  = RST_WARNING_LEVEL;
         crit_lvl  = RST_CRITICAL_LEVEL;
         pres_lvl  = RST_PRESENCE_LEVEL;
         band_w    = RST_HYST_BAND;
         margin_w  = RST_FULL_MARGIN;
         status_q  = ST_ABSENT;
         plug_flag = 1'b0;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FULL_LEVEL:     full_lvl = data;
            CSR_WARNING_LEVEL:  warn_lvl = data;
            CSR_CRITICAL_LEVEL: crit_lvl = data;
            CSR_HYST_BAND:      band_w   = data[BAND_W-1:0];
            CSR_PRESENCE_LEVEL: pres_lvl = data;
            CSR_FULL_MARGIN:    margin_w = data[BAND_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [LEVEL_W-1:0] scale(logic [ADC_BITS_DEF-1:0] code);
         int unsigned prod;
         prod = code;
         prod = prod * FULL_SCALE / MAX_CODE;
         return LEVEL_W'(prod);
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void note_sample(logic [ADC_BITS_DEF-1:0] code);
         int v, b, full, warn, crit, pres;
         level_result_type want;
         v    = int'(scale(code));
         b    = int'(band_w);
         full = int'(full_lvl);
         warn = int'(warn_lvl);
         crit = int'(crit_lvl);
         pres = int'(pres_lvl);
         // plug-in lands on ok and then falls through to the ok rules
         if (status_q == ST_ABSENT && v > pres) begin
            status_q  = ST_OK;
            plug_flag = (v >= full - int'(margin_w));
         end else if (status_q != ST_ABSENT && v <= pres) begin
            status_q = ST_ABSENT;
         end
         case (status_q)
            ST_FULL: begin
               if (v <= full - b) status_q = ST_OK;
            end
            ST_OK: begin
               if (v <= warn - b) status_q = ST_WARNING;
               else if (v > full + b) status_q = ST_FULL;
            end
            ST_WARNING: begin
               if (v <= crit - b) status_q = ST_CRITICAL;
               else if (v > warn + b) status_q = ST_OK;
            end
            ST_CRITICAL: begin
               if (v > crit + b) status_q = ST_WARNING;
            end
            default: ;
         endcase
         want.level  = scale(code);
         want.status = status_q;
         want.plug   = plug_flag;
         owed_q.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [LEVEL_W-1:0] lvl, logic [STATUS_W-1:0] st, logic flag);
         level_result_type want;
         if (owed_q.size() == 0) begin
            report_mismatch($sformatf("result with none owed: level %0d status %0d", lvl, st));
            return;
         end
         want = owed_q.pop_front();
         if (lvl !== want.level)
            report_mismatch($sformatf("level %0d, want %0d", lvl, want.level));
         if (st !== want.status)
            report_mismatch($sformatf("status %0d, want %0d (level %0d)", st, want.status,
                                      want.level));
         if (flag !== want.plug)
            report_mismatch($sformatf("plug-in flag %0b, want %0b (level %0d)", flag,
                                      want.plug, want.level));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block connections
   // -------------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [ADC_BITS_DEF-1:0] req_adc_sample = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]      rsp_level;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_full_at_plug_in;
   logic                    csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // set while both sides run with no idling at all
   bit no_idle = 1'b0;
   // last level driven; the random walk steps from here
   int walk_level = 0;

   level_scoreboard_type sb = new();

   initial begin
      forever #5 clock = ~clock;
   end

   supply_level_hysteresis_monitor i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_adc_sample      (req_adc_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_level           (rsp_level),
      .rsp_status          (rsp_status),
      .rsp_full_at_plug_in (rsp_full_at_plug_in),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // -------------------------------------------------------------------------
   // Result side: stall about 28 percent of the time, and check each item
   // taken. Values read right at the edge are the ones the block saw.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_level, rsp_status, rsp_full_at_plug_in);
   end

   // -------------------------------------------------------------------------
   // Sample side
   // -------------------------------------------------------------------------

   // Smallest code whose scaled level reaches lvl; every level 0..3300 has one.
   function automatic logic [ADC_BITS_DEF-1:0] sample_for(int lvl);
      int code;
      code = (lvl * MAX_CODE + FULL_SCALE - 1) / FULL_SCALE;
      return ADC_BITS_DEF'(code);
   endfunction

   // Offer one item, idle at random first, and hold it until it is taken.
   // Valid stays high into the next item unless that one starts with a gap.
   task automatic send_code(logic [ADC_BITS_DEF-1:0] code);
      while (!no_idle && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= code;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(code);
   endtask

   // Drop valid and hold off until the block owes nothing.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // One register write; called only while the block is drained.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= CSR_DATA_W'(value);
      @(posedge clock);
      sb.write_reg(idx, CSR_DATA_W'(value));
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly walk the level around the thresholds so the status machine
   // visits every state; some items are raw noise over the whole code range.
   task automatic next_code(output logic [ADC_BITS_DEF-1:0] code);
      int pick, lvl, stepw, anchor;
      pick  = int'($urandom_range(99));
      stepw = int'(sb.band_w) + 8;
      if (pick < 10) begin
         code = ADC_BITS_DEF'($urandom_range(MAX_CODE));
      end else begin
         if (pick < 55) begin
            lvl = walk_level + int'($urandom_range(2 * stepw)) - stepw;
         end else if (pick < 90) begin
            case ($urandom_range(4))
               0: anchor = int'(sb.full_lvl);
               1: anchor = int'(sb.warn_lvl);
               2: anchor = int'(sb.crit_lvl);
               3: anchor = int'(sb.pres_lvl);
               default: anchor = int'(sb.full_lvl) - int'(sb.margin_w);
            endcase
            // land on, just inside or just past a hysteresis edge
            lvl = anchor + (int'($urandom_range(2)) - 1) * int'(sb.band_w)
                  + int'($urandom_range(4)) - 2;
         end else begin
            lvl = int'($urandom_range(FULL_SCALE));
         end
         if (lvl < 0) lvl = 0;
         if (lvl > FULL_SCALE) lvl = FULL_SCALE;
         code = sample_for(lvl);
      end
      walk_level = int'(sb.scale(code));
   endtask

   task automatic run_random(int count);
      logic [ADC_BITS_DEF-1:0] code;
      for (int i = 0; i < count; i++) begin
         next_code(code);
         send_code(code);
         // pause now and then until the pipeline has emptied
         if (i == count / 2 || $urandom_range(199) == 0) drain_results();
      end
      drain_results();
   endtask

   // Ordered thresholds with a modest band; junk in the upper data bits of
   // the 8-bit registers must be dropped.
   task automatic set_ordered_thresholds();
      int crit, warn, full;
      crit = int'($urandom_range(1500, 150));
      warn = crit + int'($urandom_range(300));
      full = warn + int'($urandom_range(800));
      write_reg(CSR_CRITICAL_LEVEL, crit);
      write_reg(CSR_WARNING_LEVEL, warn);
      write_reg(CSR_FULL_LEVEL, full);
      write_reg(CSR_HYST_BAND, int'($urandom_range(40)) + int'($urandom_range(15)) * 256);
      write_reg(CSR_PRESENCE_LEVEL, int'($urandom_range(crit)));
      write_reg(CSR_FULL_MARGIN, int'($urandom_range(255)) + int'($urandom_range(15)) * 256);
   endtask

   task automatic apply_settings(int phase);
      case (phase)
         1: begin
            // everything at zero: present on any nonzero level
            write_reg(CSR_FULL_LEVEL, 0);
            write_reg(CSR_WARNING_LEVEL, 0);
            write_reg(CSR_CRITICAL_LEVEL, 0);
            write_reg(CSR_HYST_BAND, 0);
            write_reg(CSR_PRESENCE_LEVEL, 0);
            write_reg(CSR_FULL_MARGIN, 0);
            write_reg(CSR_SPARE_LO, int'($urandom_range(MAX_CODE)));
            write_reg(CSR_SPARE_HI, int'($urandom_range(MAX_CODE)));
         end
         2: begin
            // all ones everywhere: presence above full scale, never present
            write_reg(CSR_FULL_LEVEL, MAX_CODE);
            write_reg(CSR_WARNING_LEVEL, MAX_CODE);
            write_reg(CSR_CRITICAL_LEVEL, MAX_CODE);
            write_reg(CSR_HYST_BAND, MAX_CODE);
            write_reg(CSR_PRESENCE_LEVEL, MAX_CODE);
            write_reg(CSR_FULL_MARGIN, MAX_CODE);
            write_reg(CSR_SPARE_HI, MAX_CODE);
         end
         3: begin
            // top thresholds, widest band, presence at zero
            write_reg(CSR_PRESENCE_LEVEL, 0);
            write_reg(CSR_FULL_MARGIN, 0);
         end
         4: begin
            // tiny thresholds under a wide band: the downward limits go
            // negative and must never fire; the plug-in flag always sets
            write_reg(CSR_FULL_LEVEL, 20);
            write_reg(CSR_WARNING_LEVEL, 10);
            write_reg(CSR_CRITICAL_LEVEL, 5);
            write_reg(CSR_HYST_BAND, 200);
            write_reg(CSR_PRESENCE_LEVEL, 0);
            write_reg(CSR_FULL_MARGIN, 255);
         end
         8: begin
            // no order among the thresholds at all
            write_reg(CSR_FULL_LEVEL, int'($urandom_range(MAX_CODE)));
            write_reg(CSR_WARNING_LEVEL, int'($urandom_range(MAX_CODE)));
            write_reg(CSR_CRITICAL_LEVEL, int'($urandom_range(MAX_CODE)));
            write_reg(CSR_HYST_BAND, int'($urandom_range(MAX_CODE)));
            write_reg(CSR_PRESENCE_LEVEL, int'($urandom_range(1200)));
            write_reg(CSR_FULL_MARGIN, int'($urandom_range(MAX_CODE)));
         end
         default: set_ordered_thresholds();
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------

   // Levels under the reset thresholds: absent, plug in straight to full,
   // full->ok, ok->warning, warning->critical, hold inside the critical band,
   // climb back through warning and ok to full, unplug exactly at presence,
   // plug in one above presence (straight to warning), the plug-in flag right
   // on and one below its limit, unplug, and a final plug-in at full scale.
   int plug_walk [17] = '{0, 3300, 414, 340, 320, 340, 341, 361, 435, 100,
                          101, 100, 410, 50, 409, 100, 3300};
   // alternating and single-bit codes toggle every sample bit
   logic [ADC_BITS_DEF-1:0] bit_codes [5] = '{12'h555, 12'hAAA, 12'h001, 12'h800, 12'h7FF};

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plug_walk[k]) send_code(sample_for(plug_walk[k]));
      foreach (bit_codes[k]) send_code(bit_codes[k]);
      drain_results();

      // reset thresholds first, then one setting per phase
      run_random(150);
      for (int p = 0; p < 10; p++) begin
         apply_settings(p);
         no_idle = (p == 6);
         run_random(p == 2 ? 60 : 150);
         no_idle = 1'b0;
      end

      // let any stray result surface
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("supply_level_hysteresis_monitor verification clean");
      end else begin
         $display("supply_level_hysteresis_monitor verification failed");
      end
      $finish;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("TIMEOUT after %0t", $realtime);
      $display("supply_level_hysteresis_monitor verification failed");
      $finish;
   end

endmodule
